### sv/signal_meter_average_peak_hold_core_defines.svh
// Assertion macros shared by the level meter RTL.
`ifndef SIGNAL_METER_AVERAGE_PEAK_HOLD_CORE_DEFINES_SVH
`define SIGNAL_METER_AVERAGE_PEAK_HOLD_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define SMAPH_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("level meter check failed");
`define SMAPH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("level meter check failed");
`else
`define SMAPH_ASSERT_SAME(label, clk, rst, ante, cons)
`define SMAPH_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### sv/smaph_pkg.sv
// Shared constants, register codes and control types of the level meter.
`default_nettype none
package smaph_pkg;

  localparam int SAMPLE_BITS    = 12;
  localparam int COUNT_BITS     = 16;
  localparam int TIME_BITS      = 32;
  localparam int PERIOD_BITS    = 16;
  localparam int GAIN_BITS      = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int SUM_BITS       = SAMPLE_BITS + COUNT_BITS;
  localparam int PROD_BITS      = SAMPLE_BITS + GAIN_BITS;
  localparam int PERMILLE       = 1000;

  // Scaled width for the reciprocal divide; values below SAT_LIMIT fit it.
  localparam int QIN_BITS       = SAMPLE_BITS + 10;
  localparam int RECIP_SHIFT    = QIN_BITS + 10;
  localparam int RECIP_BITS     = RECIP_SHIFT - 9;
  localparam logic [RECIP_BITS-1:0] RECIP =
    RECIP_BITS'(((64'd1 << RECIP_SHIFT) + 64'(PERMILLE - 1)) / 64'(PERMILLE));
  localparam logic [PROD_BITS-1:0] SAT_LIMIT =
    PROD_BITS'((1 << SAMPLE_BITS) * PERMILLE);

  localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = '1;
  localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = '1;

  localparam int SQRT_STEPS = SAMPLE_BITS;
  localparam int DIV_STEPS  = SUM_BITS;
  localparam int STEP_BITS  = $clog2(DIV_STEPS);

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_AVG_PERIOD  = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_PEAK_PERIOD = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_ZERO_OFFSET = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_GAIN        = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LOG_MODE    = 3'd4;

  localparam logic [PERIOD_BITS-1:0] AVG_PERIOD_RESET  = 16'd100;
  localparam logic [PERIOD_BITS-1:0] PEAK_PERIOD_RESET = 16'd5000;
  localparam logic [GAIN_BITS-1:0]   GAIN_RESET        = 16'd1000;

  typedef struct packed {
    logic load;
    logic mul;
    logic scale;
    logic sq_init;
    logic sq_step;
    logic sq_fix;
    logic acc;
    logic div_init;
    logic div_step;
    logic update;
    logic emit;
  } smaph_cmd_t;

  typedef struct packed {
    logic log_on;
    logic closed;
  } smaph_stat_t;

endpackage
`default_nettype wire

### sv/smaph_if.sv
// Valid/ready channel interfaces for samples in and levels out.
`default_nettype none
interface smaph_in_if import smaph_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] raw_sample;
  logic [TIME_BITS-1:0]   time_ms;
  modport source (output valid, raw_sample, time_ms, input ready);
  modport sink (input valid, raw_sample, time_ms, output ready);
endinterface

interface smaph_out_if import smaph_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] level_now;
  logic [SAMPLE_BITS-1:0] level_average;
  logic [SAMPLE_BITS-1:0] level_peak;
  logic                   average_updated;
  modport source (output valid, level_now, level_average, level_peak, average_updated,
                  input ready);
  modport sink (input valid, level_now, level_average, level_peak, average_updated,
                output ready);
endinterface
`default_nettype wire

### sv/signal_meter_average_peak_hold_core.sv
// Top level of the windowed average and peak-hold signal level meter.
//
// The samples channel carries one converter reading and its millisecond
// timestamp per item; the levels channel returns exactly one result item per
// sample: the conditioned level, the current window average, the held peak and
// a flag that marks the sample which closed an averaging window. Both channels
// use valid/ready and move an item on a clock edge where both are high.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while the block is idle, which the block does not enforce;
// writes to unused indexes are dropped. One item is processed at a time. An
// accepted item is loaded, multiplied by the gain and scaled; the square-root
// response adds the root steps (one root bit per cycle), and a sample that
// closes a window adds the mean divider steps (one quotient bit per cycle);
// then the meter state is updated, the result registered and idle reentered.
// The result waits in an output register, so a stalled receiver does not stop
// the next sample from being accepted and worked on; that sample then waits
// for the register to free up before it is presented.
// A synchronous reset restores the register defaults and clears the sums,
// average, peak and window start times; no clearing pass is needed.
`default_nettype none
`include "signal_meter_average_peak_hold_core_defines.svh"
module signal_meter_average_peak_hold_core import smaph_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  smaph_in_if.sink                  samples,
  smaph_out_if.source               levels,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  smaph_cmd_t  cmd;
  smaph_stat_t stat;

  // The sequencer holds the handshakes and, unstalled, issues one step per cycle.
  smaph_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (levels.valid),
    .out_ready (levels.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // The datapath keeps the configuration, the meter state and the result register.
  smaph_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .raw_sample      (samples.raw_sample),
    .time_ms         (samples.time_ms),
    .cmd             (cmd),
    .stat            (stat),
    .level_now       (levels.level_now),
    .level_average   (levels.level_average),
    .level_peak      (levels.level_peak),
    .average_updated (levels.average_updated)
  );

  // In the cycle after it takes an item, the block is busy.
  `SMAPH_ASSERT_NEXT(a_busy_after_accept, clk, rst, samples.valid && samples.ready, !samples.ready)
  // A window close always leaves the peak at or above the new average.
  `SMAPH_ASSERT_SAME(a_peak_covers_average, clk, rst, levels.valid && levels.average_updated, levels.level_peak >= levels.level_average)
  // A new result only appears when the block was busy just before it.
  `SMAPH_ASSERT_SAME(a_result_after_work, clk, rst, $rose(levels.valid), $past(!samples.ready))

endmodule
`default_nettype wire

### sv/smaph_dp.sv
// Datapath of the level meter: conditioning, square root, accumulator, divider.
`default_nettype none
module smaph_dp import smaph_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  input  logic [SAMPLE_BITS-1:0]    raw_sample,
  input  logic [TIME_BITS-1:0]      time_ms,
  input  smaph_cmd_t                cmd,
  output smaph_stat_t               stat,
  output logic [SAMPLE_BITS-1:0]    level_now,
  output logic [SAMPLE_BITS-1:0]    level_average,
  output logic [SAMPLE_BITS-1:0]    level_peak,
  output logic                      average_updated
);

  localparam int REM_BITS = SAMPLE_BITS + 3;

  logic [PERIOD_BITS-1:0] avg_period;
  logic [PERIOD_BITS-1:0] peak_period;
  logic [SAMPLE_BITS-1:0] zero_offset;
  logic [GAIN_BITS-1:0]   gain;
  logic                   log_mode;

  logic [TIME_BITS-1:0]     now;
  logic [SAMPLE_BITS-1:0]   lvl_off;
  logic [PROD_BITS-1:0]     prod;
  logic [SAMPLE_BITS-1:0]   level;
  logic [2*SAMPLE_BITS-1:0] xs;
  logic [REM_BITS-1:0]      rem;
  logic [SAMPLE_BITS-1:0]   root;
  logic [SUM_BITS-1:0]      level_sum;
  logic [COUNT_BITS-1:0]    sample_count;
  logic                     closed;
  logic [SUM_BITS-1:0]      quo;
  logic [COUNT_BITS:0]      drem;
  logic [SAMPLE_BITS-1:0]   average;
  logic [SAMPLE_BITS-1:0]   peak;
  logic [TIME_BITS-1:0]     avg_start;
  logic [TIME_BITS-1:0]     peak_start;

  logic [SAMPLE_BITS-1:0]          inv;
  logic [QIN_BITS+RECIP_BITS-1:0]  recip_prod;
  logic [REM_BITS-1:0]             rem_sh;
  logic [REM_BITS-1:0]             trial;
  logic [COUNT_BITS:0]             drem_sh;
  logic [PERIOD_BITS-1:0]          avg_eff;
  logic [PERIOD_BITS-1:0]          peak_eff;
  logic [TIME_BITS-1:0]            avg_elapsed;
  logic [TIME_BITS-1:0]            peak_elapsed;
  logic [SAMPLE_BITS-1:0]          avg_new;
  logic [SAMPLE_BITS-1:0]          peak_raised;

  always_comb begin
    inv          = ~raw_sample;
    recip_prod   = prod[QIN_BITS-1:0] * RECIP;
    rem_sh       = {rem[REM_BITS-3:0], xs[2*SAMPLE_BITS-1 -: 2]};
    trial        = REM_BITS'({root, 2'b01});
    drem_sh      = {drem[COUNT_BITS-1:0], quo[SUM_BITS-1]};
    avg_eff      = (avg_period == '0) ? PERIOD_BITS'(1) : avg_period;
    peak_eff     = (peak_period < avg_eff) ? avg_eff : peak_period;
    avg_elapsed  = now - avg_start;
    peak_elapsed = now - peak_start;
    avg_new      = closed ? quo[SAMPLE_BITS-1:0] : average;
    peak_raised  = (closed && (avg_new > peak)) ? avg_new : peak;
    stat.log_on  = log_mode;
    stat.closed  = closed;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_period  <= AVG_PERIOD_RESET;
      peak_period <= PEAK_PERIOD_RESET;
      zero_offset <= '0;
      gain        <= GAIN_RESET;
      log_mode    <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_AVG_PERIOD:  avg_period  <= cfg_data[PERIOD_BITS-1:0];
        CFG_PEAK_PERIOD: peak_period <= cfg_data[PERIOD_BITS-1:0];
        CFG_ZERO_OFFSET: zero_offset <= cfg_data[SAMPLE_BITS-1:0];
        CFG_GAIN:        gain        <= cfg_data[GAIN_BITS-1:0];
        CFG_LOG_MODE:    log_mode    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Per-item working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now     <= time_ms;
      lvl_off <= (inv > zero_offset) ? (inv - zero_offset) : '0;
    end
    if (cmd.mul) begin
      prod <= PROD_BITS'(lvl_off) * PROD_BITS'(gain);
    end
    if (cmd.scale) begin
      level <= (prod >= SAT_LIMIT) ? FULL_SCALE : recip_prod[RECIP_SHIFT +: SAMPLE_BITS];
    end
    if (cmd.sq_init) begin
      xs   <= {level, {SAMPLE_BITS{1'b0}}} - {{SAMPLE_BITS{1'b0}}, level};
      rem  <= '0;
      root <= '0;
    end
    if (cmd.sq_step) begin
      xs <= {xs[2*SAMPLE_BITS-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[SAMPLE_BITS-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[SAMPLE_BITS-2:0], 1'b0};
      end
    end
    if (cmd.sq_fix) begin
      // Round half up: the remainder exceeds the root exactly when x > r*r + r.
      level <= (rem > REM_BITS'(root)) ? (root + 1'b1) : root;
    end
    if (cmd.div_init) begin
      quo  <= level_sum;
      drem <= '0;
    end
    if (cmd.div_step) begin
      if (drem_sh >= {1'b0, sample_count}) begin
        drem <= drem_sh - {1'b0, sample_count};
        quo  <= {quo[SUM_BITS-2:0], 1'b1};
      end else begin
        drem <= drem_sh;
        quo  <= {quo[SUM_BITS-2:0], 1'b0};
      end
    end
    if (cmd.emit) begin
      level_now       <= level;
      level_average   <= average;
      level_peak      <= peak;
      average_updated <= closed;
    end
  end

  // Meter state that persists across items.
  always_ff @(posedge clk) begin
    if (rst) begin
      level_sum    <= '0;
      sample_count <= '0;
      closed       <= 1'b0;
      average      <= '0;
      peak         <= '0;
      avg_start    <= '0;
      peak_start   <= '0;
    end else begin
      if (cmd.acc) begin
        if (sample_count != COUNT_MAX) begin
          level_sum    <= level_sum + SUM_BITS'(level);
          sample_count <= sample_count + 1'b1;
        end
        closed <= (avg_elapsed >= TIME_BITS'(avg_eff));
      end
      if (cmd.update) begin
        average <= avg_new;
        if (closed) begin
          level_sum    <= '0;
          sample_count <= '0;
          avg_start    <= now;
        end
        if (peak_elapsed >= TIME_BITS'(peak_eff)) begin
          peak_start <= now;
          peak       <= avg_new;
        end else begin
          peak <= peak_raised;
        end
      end
    end
  end

endmodule
`default_nettype wire

### sv/smaph_ctrl.sv
// Sequencer of the level meter: steps the datapath and owns the handshakes.
`default_nettype none
module smaph_ctrl import smaph_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  smaph_stat_t stat,
  output smaph_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_MUL    = 11'b00000000010,
    S_SCALE  = 11'b00000000100,
    S_SQINIT = 11'b00000001000,
    S_SQRT   = 11'b00000010000,
    S_SQFIX  = 11'b00000100000,
    S_ACC    = 11'b00001000000,
    S_TEST   = 11'b00010000000,
    S_DIV    = 11'b00100000000,
    S_UPD    = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } smaph_state_t;

  localparam logic [STEP_BITS-1:0] SQRT_LAST = STEP_BITS'(SQRT_STEPS - 1);
  localparam logic [STEP_BITS-1:0] DIV_LAST  = STEP_BITS'(DIV_STEPS - 1);

  smaph_state_t         state;
  smaph_state_t         state_next;
  logic [STEP_BITS-1:0] step;
  logic [STEP_BITS-1:0] step_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = stat.log_on ? S_SQINIT : S_ACC;
      end
      S_SQINIT: begin
        cmd.sq_init = 1'b1;
        step_next   = '0;
        state_next  = S_SQRT;
      end
      S_SQRT: begin
        cmd.sq_step = 1'b1;
        step_next   = step + 1'b1;
        if (step == SQRT_LAST) begin
          state_next = S_SQFIX;
        end
      end
      S_SQFIX: begin
        cmd.sq_fix = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc    = 1'b1;
        state_next = S_TEST;
      end
      S_TEST: begin
        cmd.div_init = 1'b1;
        step_next    = '0;
        state_next   = stat.closed ? S_DIV : S_UPD;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == DIV_LAST) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### bench/signal_meter_average_peak_hold_core_test.sv
// Self-checking bench for the level meter: directed and random samples against a local predictor.
module signal_meter_average_peak_hold_core_test;
  import smaph_pkg::*;

  localparam int LIMIT_CYCLES  = 20_000_000;
  localparam int MAX_REPORTS   = 10;
  localparam int DRAIN_CYCLES  = 60;
  localparam int RANDOM_PHASES = 15;
  localparam int PHASE_ITEMS   = 50;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LAST = CFG_LOG_MODE;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] raw;
    logic [TIME_BITS-1:0]   stamp;
  } sample_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] now;
    logic [SAMPLE_BITS-1:0] average;
    logic [SAMPLE_BITS-1:0] peak;
    logic                   closed;
  } levels_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  smaph_in_if  samples();
  smaph_out_if levels();

  signal_meter_average_peak_hold_core dut (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .levels    (levels),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor copy of the registers and the meter state.
  logic [PERIOD_BITS-1:0] avg_period_cfg;
  logic [PERIOD_BITS-1:0] peak_period_cfg;
  logic [SAMPLE_BITS-1:0] zero_offset_cfg;
  logic [GAIN_BITS-1:0]   gain_cfg;
  logic                   log_cfg;
  logic [SUM_BITS-1:0]    window_sum;
  logic [COUNT_BITS-1:0]  window_count;
  logic [SAMPLE_BITS-1:0] held_average;
  logic [SAMPLE_BITS-1:0] held_peak;
  logic [TIME_BITS-1:0]   avg_window_start;
  logic [TIME_BITS-1:0]   peak_window_start;

  sample_t pending_samples[$];
  levels_t expected_levels[$];
  sample_t launch;
  levels_t got;
  levels_t want;
  levels_t predicted;

  bit          idle_on;
  int unsigned send_gap;
  int unsigned recv_stall;
  int unsigned failures;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned windows_closed;
  int unsigned log_samples;
  int unsigned settings;
  int unsigned cycles;

  // Inversion, offset, permille gain with saturation, then the optional rounded root.
  function automatic logic [SAMPLE_BITS-1:0] condition_level(logic [SAMPLE_BITS-1:0] raw);
    logic [SAMPLE_BITS-1:0] inv;
    logic [SAMPLE_BITS-1:0] above;
    logic [63:0]            scaled;
    logic [63:0]            x;
    logic [63:0]            r;
    logic [63:0]            t;
    inv = FULL_SCALE - raw;
    above = (inv <= zero_offset_cfg) ? '0 : inv - zero_offset_cfg;
    scaled = 64'(above) * 64'(gain_cfg) / 64'(PERMILLE);
    if (scaled > 64'(FULL_SCALE)) scaled = 64'(FULL_SCALE);
    if (!log_cfg) return scaled[SAMPLE_BITS-1:0];
    x = scaled * 64'(FULL_SCALE);
    r = '0;
    for (int b = SAMPLE_BITS - 1; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    // Round half up on the exact integer root.
    if (x > r * r + r) r = r + 64'd1;
    return r[SAMPLE_BITS-1:0];
  endfunction

  function automatic levels_t meter_levels(sample_t s);
    logic [SAMPLE_BITS-1:0] lvl;
    logic [TIME_BITS-1:0]   avg_len;
    logic [TIME_BITS-1:0]   peak_len;
    logic [TIME_BITS-1:0]   elapsed;
    levels_t                res;
    lvl = condition_level(s.raw);
    // A full count freezes both sum and count until the window closes.
    if (window_count != COUNT_MAX) begin
      window_sum = window_sum + SUM_BITS'(lvl);
      window_count = window_count + 1'b1;
    end
    avg_len = (avg_period_cfg == '0) ? TIME_BITS'(1) : TIME_BITS'(avg_period_cfg);
    peak_len = (TIME_BITS'(peak_period_cfg) < avg_len) ? avg_len : TIME_BITS'(peak_period_cfg);
    res.closed = 1'b0;
    elapsed = s.stamp - avg_window_start;
    if (elapsed >= avg_len) begin
      held_average = SAMPLE_BITS'(window_sum / SUM_BITS'(window_count));
      if (held_average > held_peak) held_peak = held_average;
      window_sum = '0;
      window_count = '0;
      avg_window_start = s.stamp;
      res.closed = 1'b1;
    end
    elapsed = s.stamp - peak_window_start;
    if (elapsed >= peak_len) begin
      peak_window_start = s.stamp;
      held_peak = held_average;
    end
    res.now = lvl;
    res.average = held_average;
    res.peak = held_peak;
    return res;
  endfunction

  task automatic queue_sample(logic [SAMPLE_BITS-1:0] raw, logic [TIME_BITS-1:0] stamp);
    pending_samples.push_back('{raw: raw, stamp: stamp});
  endtask

  // Returns at a falling edge once every queued item has been sent and answered.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_samples.size() != 0 || samples.valid || expected_levels.size() != 0);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      CFG_AVG_PERIOD:  avg_period_cfg = data;
      CFG_PEAK_PERIOD: peak_period_cfg = data;
      CFG_ZERO_OFFSET: zero_offset_cfg = data[SAMPLE_BITS-1:0];
      CFG_GAIN:        gain_cfg = data;
      CFG_LOG_MODE:    log_cfg = data[0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Writes all registers while the block is idle, with junk in the unused upper bits
  // and one write to an index past the register list, which must be dropped.
  task automatic configure(int unsigned avg, int unsigned peak, int unsigned zoff,
                           int unsigned gn, int unsigned lg);
    wait_drained();
    write_reg(CFG_AVG_PERIOD, CFG_DATA_BITS'(avg));
    write_reg(CFG_PEAK_PERIOD, CFG_DATA_BITS'(peak));
    write_reg(CFG_ZERO_OFFSET, (CFG_DATA_BITS'($urandom) & ~CFG_DATA_BITS'(FULL_SCALE)) |
                               CFG_DATA_BITS'(zoff));
    write_reg(CFG_GAIN, CFG_DATA_BITS'(gn));
    write_reg(CFG_LOG_MODE, (CFG_DATA_BITS'($urandom) & ~CFG_DATA_BITS'(1)) |
                            CFG_DATA_BITS'(lg & 1));
    write_reg(CFG_INDEX_BITS'($urandom_range(int'(CFG_LAST) + 1, (1 << CFG_INDEX_BITS) - 1)),
              CFG_DATA_BITS'($urandom));
    settings++;
    @(negedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("signal_meter_average_peak_hold_core regression: fail");
      $finish;
    end
  end

  // Driver: one item at a time from the pending queue, with a random gap after each if idle_on.
  always @(posedge clk) begin
    if (rst) begin
      samples.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (samples.valid && samples.ready) begin
        predicted = meter_levels('{raw: samples.raw_sample, stamp: samples.time_ms});
        expected_levels.push_back(predicted);
        items_sent++;
        if (predicted.closed) windows_closed++;
        if (log_cfg) log_samples++;
      end
      if (!samples.valid || samples.ready) begin
        if (send_gap != 0) begin
          samples.valid <= 1'b0;
          send_gap--;
        end else if (pending_samples.size() != 0) begin
          launch = pending_samples.pop_front();
          samples.valid <= 1'b1;
          samples.raw_sample <= launch.raw;
          samples.time_ms <= launch.stamp;
          send_gap = idle_on ? $urandom_range(0, 6) : 0;
        end else begin
          samples.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest prediction, then stalls at random if idle_on.
  always @(posedge clk) begin
    if (rst) begin
      levels.ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (levels.valid && levels.ready) begin
        got.now = levels.level_now;
        got.average = levels.level_average;
        got.peak = levels.level_peak;
        got.closed = levels.average_updated;
        if (expected_levels.size() == 0) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("unexpected level item: now %0d average %0d peak %0d updated %0b",
                     got.now, got.average, got.peak, got.closed);
        end else begin
          want = expected_levels.pop_front();
          results_checked++;
          if (got.now !== want.now || got.average !== want.average ||
              got.peak !== want.peak || got.closed !== want.closed) begin
            failures++;
            if (failures <= MAX_REPORTS)
              $display("level mismatch on result %0d: expected %0d/%0d/%0d/%0b got %0d/%0d/%0d/%0b",
                       results_checked, want.now, want.average, want.peak, want.closed,
                       got.now, got.average, got.peak, got.closed);
          end
        end
        recv_stall = idle_on ? $urandom_range(0, 6) : 0;
      end
      if (recv_stall != 0) begin
        levels.ready <= 1'b0;
        recv_stall--;
      end else begin
        levels.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [TIME_BITS-1:0] stamp;
    logic [TIME_BITS-1:0] base;
    logic [SAMPLE_BITS-1:0] raw;
    int unsigned avg;
    int unsigned peak;
    int unsigned zoff;
    int unsigned gn;
    int unsigned step_span;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    samples.valid = 1'b0;
    samples.raw_sample = '0;
    samples.time_ms = '0;
    levels.ready = 1'b0;
    idle_on = 1'b1;
    avg_period_cfg = AVG_PERIOD_RESET;
    peak_period_cfg = PEAK_PERIOD_RESET;
    zero_offset_cfg = '0;
    gain_cfg = GAIN_RESET;
    log_cfg = 1'b0;
    window_sum = '0;
    window_count = '0;
    held_average = '0;
    held_peak = '0;
    avg_window_start = '0;
    peak_window_start = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Register defaults straight out of reset: a window closes at 100 ms and the
    // peak window at 5000 ms, where the peak falls back to the new average.
    queue_sample(12'd0, 32'd0);
    queue_sample(12'd4095, 32'd50);
    queue_sample(12'd2048, 32'd100);
    queue_sample(12'd1000, 32'd5100);
    queue_sample(12'd0, 32'd5101);

    // Zero periods act as one millisecond; an offset at full scale zeroes every level.
    configure(0, 0, 4095, 65535, 0);
    queue_sample(12'd0, 32'd5101);
    queue_sample(12'd0, 32'd5102);
    queue_sample(12'd4095, 32'd5102);

    // Maximum gain saturates strong readings.
    configure(1, 65535, 0, 65535, 0);
    queue_sample(12'd0, 32'd5103);
    queue_sample(12'd4000, 32'd5104);
    queue_sample(12'd4090, 32'd5105);
    queue_sample(12'd4095, 32'd5106);

    // Zero gain under the root response, with a peak period shorter than the average.
    configure(3, 2, 100, 0, 1);
    queue_sample(12'd0, 32'd5107);
    queue_sample(12'd2000, 32'd5110);
    queue_sample(12'd4095, 32'd5111);

    // Root rounding: level 1 rounds up, level 2 sits on the boundary and stays down.
    configure(2, 5, 0, 1000, 1);
    queue_sample(12'd0, 32'd5113);
    queue_sample(12'd4094, 32'd5115);
    queue_sample(12'd4093, 32'd5117);
    queue_sample(12'd4095, 32'd5118);

    // Timestamps wrapping through zero.
    configure(10, 20, 0, 1000, 0);
    queue_sample(12'($urandom), 32'hFFFF_FFF8);
    queue_sample(12'($urandom), 32'h0000_0002);
    queue_sample(12'($urandom), 32'h0000_0005);
    queue_sample(12'($urandom), 32'h0000_000C);

    // Longest window: one ms short of it stays open, the full length closes it.
    configure(65535, 65535, 0, 1000, 0);
    base = 32'h8000_0000;
    queue_sample(12'($urandom), base);
    queue_sample(12'($urandom), base + 32'd65534);
    queue_sample(12'($urandom), base + 32'd65535);

    stamp = base + 32'd65535;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 9))
        0: avg = 0;
        1: avg = 1;
        2: avg = 65535;
        3: avg = $urandom_range(0, 65535);
        default: avg = $urandom_range(2, 12);
      endcase
      case ($urandom_range(0, 9))
        0: peak = 0;
        1: peak = 65535;
        2: peak = avg;
        3: peak = $urandom_range(0, 65535);
        default: peak = $urandom_range(1, 40);
      endcase
      case ($urandom_range(0, 9))
        0: zoff = 0;
        1: zoff = 4095;
        2: zoff = $urandom_range(0, 4095);
        default: zoff = $urandom_range(0, 400);
      endcase
      case ($urandom_range(0, 9))
        0: gn = 0;
        1: gn = 65535;
        2: gn = 1000;
        3: gn = $urandom_range(0, 65535);
        default: gn = $urandom_range(500, 4000);
      endcase
      configure(avg, peak, zoff, gn, $urandom_range(0, 1));
      // Every third phase runs with both sides at full rate.
      idle_on = (p % 3) != 2;
      if ($urandom_range(0, 3) == 0) stamp = $urandom;
      step_span = (avg == 0) ? 1 : avg;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(0, 19))
          0:       stamp = stamp + TIME_BITS'($urandom);
          1, 2:    stamp = stamp + TIME_BITS'(step_span);
          3, 4, 5: stamp = stamp + TIME_BITS'($urandom_range(0, step_span));
          default: stamp = stamp + TIME_BITS'($urandom_range(0, 3));
        endcase
        if ($urandom_range(0, 9) == 0)
          raw = $urandom_range(0, 1) ? FULL_SCALE : '0;
        else
          raw = SAMPLE_BITS'($urandom);
        queue_sample(raw, stamp);
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("ran %0d samples under %0d register settings; %0d closed an averaging window",
             items_sent, settings, windows_closed);
    $display("%0d samples used the root response; %0d results checked, %0d failures",
             log_samples, results_checked, failures);
    if (failures == 0 && expected_levels.size() == 0)
      $display("signal_meter_average_peak_hold_core regression: pass");
    else
      $display("signal_meter_average_peak_hold_core regression: fail");
    $finish;
  end

endmodule
